/* rtl/core/cmac_pkg.sv */
`timescale 1ns / 1ps
package cmac_pkg;

   typedef struct packed {
      logic [63:0] block_high;
      logic [63:0] block_low;
      logic [4:0]  byte_count;
      logic        msg_end;
   } req_type;

   typedef struct packed {
      logic [63:0] tag_high;
      logic [63:0] tag_low;
   } rsp_type;

   // prepared block handed from front end to engine
   typedef struct packed {
      logic [127:0] data;
      logic         last;
      logic         use_k2;
   } job_type;

   localparam logic [1:0] CSR_KEY_HIGH   = 2'd0;
   localparam logic [1:0] CSR_KEY_LOW    = 2'd1;
   localparam logic [1:0] CSR_TAG_LENGTH = 2'd2;
   localparam logic [7:0] DBL_POLY       = 8'h87;
   localparam logic [7:0] PAD_BYTE       = 8'h80;
   localparam int         QUEUE_DEPTH    = 2;

   localparam logic [7:0] SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // byte mask keeping the first n bytes of a 128-bit word
   function automatic logic [127:0] keep_mask(input logic [4:0] n);
      logic [127:0] m;
      m = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) < n) begin
            m[127 - 8 * i -: 8] = 8'hff;
         end
      end
      return m;
   endfunction

   function automatic logic [7:0] xt(input logic [7:0] b);
      return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
   endfunction

   function automatic logic [31:0] sub_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // sub bytes, shift rows and optional mix columns
   function automatic logic [127:0] aes_round(input logic [127:0] s_in, input logic mix);
      logic [7:0]   s [16];
      logic [7:0]   t [16];
      logic [7:0]   a0, a1, a2, a3, al;
      logic [127:0] r;
      for (int i = 0; i < 16; i++) begin
         s[i] = SBOX[s_in[127 - 8 * i -: 8]];
      end
      for (int c = 0; c < 4; c++) begin
         for (int i = 0; i < 4; i++) begin
            t[i + 4 * c] = s[i + 4 * ((c + i) % 4)];
         end
      end
      if (mix) begin
         for (int c = 0; c < 4; c++) begin
            a0 = t[4 * c];
            a1 = t[4 * c + 1];
            a2 = t[4 * c + 2];
            a3 = t[4 * c + 3];
            al = a0 ^ a1 ^ a2 ^ a3;
            t[4 * c]     = a0 ^ al ^ xt(a0 ^ a1);
            t[4 * c + 1] = a1 ^ al ^ xt(a1 ^ a2);
            t[4 * c + 2] = a2 ^ al ^ xt(a2 ^ a3);
            t[4 * c + 3] = a3 ^ al ^ xt(a3 ^ a0);
         end
      end
      for (int i = 0; i < 16; i++) begin
         r[127 - 8 * i -: 8] = t[i];
      end
      return r;
   endfunction

   // next round key from the previous one
   function automatic logic [127:0] next_key(input logic [127:0] k, input logic [7:0] rc);
      logic [31:0] w0, w1, w2, w3, tw;
      w3 = k[31:0];
      tw = sub_word({w3[23:0], w3[31:24]}) ^ {rc, 24'h0};
      w0 = k[127:96] ^ tw;
      w1 = k[95:64] ^ w0;
      w2 = k[63:32] ^ w1;
      return {w0, w1, w2, w3 ^ w2};
   endfunction

   function automatic logic [127:0] dbl(input logic [127:0] v);
      return {v[126:0], 1'b0} ^ {120'h0, v[127] ? DBL_POLY : 8'h00};
   endfunction

endpackage

/* rtl/core/cmac_front.sv */
`timescale 1ns / 1ps
module cmac_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   output logic                 full,
   input  cmac_pkg::req_type    req_word,
   output logic                 job_valid,
   input  logic                 job_take,
   output cmac_pkg::job_type    job_word
);

   cmac_pkg::job_type job_q_ff [cmac_pkg::QUEUE_DEPTH];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff;
   cmac_pkg::job_type job_in;
   logic [127:0]      pad_bits;
   logic [127:0]      raw;
   logic              do_push, do_pop;

   // pad and classify the incoming block
   always_comb begin
      raw      = {req_word.block_high, req_word.block_low};
      pad_bits = '0;
      for (int i = 0; i < 16; i++) begin
         if (5'(i) == req_word.byte_count) begin
            pad_bits[127 - 8 * i -: 8] = cmac_pkg::PAD_BYTE;
         end
      end
      job_in.last   = req_word.msg_end;
      job_in.use_k2 = req_word.msg_end && (req_word.byte_count < 5'd16);
      if (job_in.use_k2) begin
         job_in.data = (raw & cmac_pkg::keep_mask(req_word.byte_count)) | pad_bits;
      end else begin
         job_in.data = raw;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign job_valid = (count_ff != 2'd0);
   assign job_word  = job_q_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = job_take && job_valid;

   // two-entry word queue
   always_ff @(posedge clock) begin
      if (do_push) begin
         job_q_ff[wr_ptr_ff] <= job_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
   end

endmodule

/* rtl/core/cmac_engine.sv */
`timescale 1ns / 1ps
module cmac_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data,
   input  logic              job_valid,
   output logic              job_take,
   input  cmac_pkg::job_type job_word,
   output logic              empty,
   input  logic              pop,
   output cmac_pkg::rsp_type rsp_word
);

   typedef enum logic [1:0] {ST_IDLE, ST_DERIVE, ST_RUN} state_type;

   state_type     state_ff;
   logic [127:0]  key_ff;
   logic [4:0]    tag_len_ff;
   logic          ready_ff;
   logic [127:0]  k1_ff, k2_ff;
   logic [127:0]  chain_ff;
   logic [127:0]  st_ff;
   logic [127:0]  rk_ff;
   logic [3:0]    round_ff;
   logic [7:0]    rc_ff;
   logic          last_ff;
   logic          out_full_ff;
   cmac_pkg::rsp_type out_ff;
   logic [127:0]  rk_in, st_in, block_in, tag;
   logic [4:0]    tl;

   assign csr_ready = 1'b1;
   assign empty     = !out_full_ff;
   assign rsp_word  = out_ff;
   // start a block when subkeys exist and the result slot is free
   assign job_take  = (state_ff == ST_IDLE) && job_valid && ready_ff
                      && (!out_full_ff || pop);

   always_comb begin
      rk_in = cmac_pkg::next_key(rk_ff, rc_ff);
      st_in = cmac_pkg::aes_round(st_ff, round_ff != 4'd10) ^ rk_in;
      if (!job_word.last)       block_in = job_word.data;
      else if (job_word.use_k2) block_in = job_word.data ^ k2_ff;
      else                      block_in = job_word.data ^ k1_ff;
      tl  = (tag_len_ff > 5'd16) ? 5'd16 : tag_len_ff;
      tag = st_in & cmac_pkg::keep_mask(tl);
   end

   // round sequencer, one aes round a cycle, round keys on the fly
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         key_ff      <= '0;
         tag_len_ff  <= 5'd16;
         ready_ff    <= 1'b0;
         chain_ff    <= '0;
         out_full_ff <= 1'b0;
      end else begin
         if (pop && out_full_ff) out_full_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (!ready_ff && job_valid) begin
                  st_ff    <= key_ff;
                  rk_ff    <= key_ff;
                  rc_ff    <= 8'h01;
                  round_ff <= 4'd1;
                  state_ff <= ST_DERIVE;
               end else if (job_take) begin
                  st_ff    <= chain_ff ^ block_in ^ key_ff;
                  rk_ff    <= key_ff;
                  rc_ff    <= 8'h01;
                  round_ff <= 4'd1;
                  last_ff  <= job_word.last;
                  state_ff <= ST_RUN;
               end
            end
            ST_DERIVE, ST_RUN: begin
               st_ff    <= st_in;
               rk_ff    <= rk_in;
               rc_ff    <= cmac_pkg::xt(rc_ff);
               round_ff <= round_ff + 4'd1;
               if (round_ff == 4'd10) begin
                  state_ff <= ST_IDLE;
                  if (state_ff == ST_DERIVE) begin
                     k1_ff    <= cmac_pkg::dbl(st_in);
                     k2_ff    <= cmac_pkg::dbl(cmac_pkg::dbl(st_in));
                     ready_ff <= 1'b1;
                  end else if (last_ff) begin
                     chain_ff    <= '0;
                     out_ff      <= {tag[127:64], tag[63:0]};
                     out_full_ff <= 1'b1;
                  end else begin
                     chain_ff <= st_in;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // register writes must arrive only while idle; the block itself does not enforce this
         if (csr_valid) begin
            case (csr_index)
               cmac_pkg::CSR_KEY_HIGH: begin
                  key_ff[127:64] <= csr_data;
                  ready_ff       <= 1'b0;
               end
               cmac_pkg::CSR_KEY_LOW: begin
                  key_ff[63:0] <= csr_data;
                  ready_ff     <= 1'b0;
               end
               cmac_pkg::CSR_TAG_LENGTH: tag_len_ff <= csr_data[4:0];
               default: ;
            endcase
         end
      end
   end

endmodule

/* rtl/core/aes128_cmac_top.sv */
`timescale 1ns / 1ps
// AES-128 CMAC: push 16-byte message words with a byte count and last flag; one tag
// word comes out per message. Each block is a load plus ten rounds in the single
// shared AES round unit, keys expanded on the fly; the first block after reset or a
// key write is preceded by a load plus ten rounds deriving subkeys. A two-word queue
// on the input and a one-word result register let both sides stall independently.
// csr_index 0/1 write key high/low, 2 writes tag length; writes only while idle.
module aes128_cmac_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   output logic              full,
   input  cmac_pkg::req_type req_word,
   output logic              empty,
   input  logic              pop,
   output cmac_pkg::rsp_type rsp_word,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [63:0]       csr_data
);

   logic              job_valid, job_take;
   cmac_pkg::job_type job_word;

   // front end: padding and queue
   cmac_front u_front (
      .clock, .reset, .push, .full, .req_word,
      .job_valid, .job_take, .job_word
   );

   // back end: aes rounds and tag
   cmac_engine u_engine (
      .clock, .reset, .csr_valid, .csr_ready, .csr_index, .csr_data,
      .job_valid, .job_take, .job_word, .empty, .pop, .rsp_word
   );

endmodule
